[design/lrd_pkg.sv]
// shared types for the lzss ring decoder: controller states, token phase, command and status
`default_nettype none

package lrd_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_DECODE,
    ST_COPY
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_LIT  = 2'd1,
    PH_POS  = 2'd2
  } token_phase_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;     // latch the input byte
    logic stream_reset;  // write pointer, kept count, position back to stream start
    logic sweep_step;    // write one ring entry of the clear or fill pass
    logic sweep_zero;    // sweep value is zero, else space
    logic sweep_done;    // last entry of the pass, sweep address back to zero
    logic save_pos;      // first match byte holds the low position bits
    logic emit_lit;      // literal byte out and into the ring
    logic copy_start;    // issue the first ring read of a match
    logic copy_emit;     // copied byte out and back into the ring
  } lrd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [7:0] cur_byte;
    logic       out_free;
    logic       copy_last;
    logic       fill_end;
    logic       ring_end;
  } lrd_stat_t;

endpackage

`default_nettype wire

[design/lrd_datapath.sv]
// datapath: history ring memory, pointers, copy counter, kept count and output register
`default_nettype none

module lrd_datapath
  import lrd_pkg::*;
#(
  parameter int RING_SIZE        = 1024,
  parameter int MAX_MATCH        = 18,
  parameter int MIN_MATCH_OFFSET = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lrd_cmd_t    cmd,
  input  wire logic [23:0] capacity,
  input  wire logic [7:0]  byte_in,
  input  wire logic        out_ready,
  output lrd_stat_t        stat,
  output logic             out_valid,
  output logic [7:0]       byte_value,
  output logic             kept,
  output logic             run_last,
  output logic [23:0]      kept_total
);

  localparam int AW        = $clog2(RING_SIZE);
  localparam int CW        = $clog2(MAX_MATCH + 1);
  localparam int WP_START  = RING_SIZE - MAX_MATCH;
  localparam int FILL_LAST = RING_SIZE - MAX_MATCH - 1;

  logic [7:0]    mem [RING_SIZE];

  logic [7:0]    cur_byte;
  logic [7:0]    pos_low;
  logic [AW-1:0] wp;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_next;
  logic [7:0]    rd_data;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [CW-1:0] copy_cnt;
  logic [23:0]   kept_count;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    copy_data;
  logic          emit;
  logic          keep;
  logic [AW-1:0] pos_mod;
  logic [CW-1:0] match_len;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == AW'(RING_SIZE - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [3:0] byte_in_hi(input logic [7:0] b);
    byte_in_hi = b[7:4];
  endfunction

  // match position modulo the ring, quotient is below sixteen
  always_comb begin
    logic [16:0] pos_ext;
    logic [16:0] pos_red;
    pos_ext = {5'd0, byte_in_hi(cur_byte), pos_low};
    pos_red = pos_ext;
    for (int m = 1; m < 16; m++) begin
      if (pos_ext >= 17'(m * RING_SIZE)) begin
        pos_red = pos_ext - 17'(m * RING_SIZE);
      end
    end
    pos_mod = pos_red[AW-1:0];
  end

  always_comb begin
    logic [5:0] len_raw;
    len_raw = 6'(cur_byte[3:0]) + 6'(MIN_MATCH_OFFSET + 1);
    if (len_raw > 6'(MAX_MATCH)) begin
      match_len = CW'(MAX_MATCH);
    end else begin
      match_len = len_raw[CW-1:0];
    end
  end

  assign copy_data = fwd_hit ? fwd_data : rd_data;
  assign emit      = cmd.emit_lit | cmd.copy_emit;
  assign keep      = kept_count < capacity;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp;
    wr_data = copy_data;
    if (cmd.sweep_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_addr;
      wr_data = cmd.sweep_zero ? 8'd0 : SPACE_BYTE;
    end else if (cmd.emit_lit) begin
      wr_en   = 1'b1;
      wr_data = cur_byte;
    end else if (cmd.copy_emit) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    rd_addr_next = rd_addr;
    if (cmd.copy_start) begin
      rd_addr_next = pos_mod;
    end else if (cmd.copy_emit) begin
      rd_addr_next = ring_inc(rd_addr);
    end
  end

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data  <= mem[rd_addr_next];
    fwd_data <= wr_data;
    rd_addr  <= rd_addr_next;
    if (cmd.take_item) begin
      cur_byte <= byte_in;
    end
    if (emit) begin
      byte_value <= wr_data;
      kept       <= keep;
      run_last   <= cmd.emit_lit | (copy_cnt == CW'(1));
      kept_total <= keep ? kept_count + 24'd1 : kept_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit    <= 1'b0;
      pos_low    <= '0;
      wp         <= AW'(WP_START);
      sweep_addr <= '0;
      copy_cnt   <= '0;
      kept_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      fwd_hit <= wr_en && (wr_addr == rd_addr_next);
      if (cmd.sweep_step) begin
        sweep_addr <= cmd.sweep_done ? '0 : sweep_addr + AW'(1);
      end
      if (cmd.stream_reset) begin
        wp         <= AW'(WP_START);
        kept_count <= '0;
        pos_low    <= '0;
      end else begin
        if (emit) begin
          wp <= ring_inc(wp);
          if (keep) begin
            kept_count <= kept_count + 24'd1;
          end
        end
        if (cmd.save_pos) begin
          pos_low <= cur_byte;
        end
      end
      if (cmd.copy_start) begin
        copy_cnt <= match_len;
      end else if (cmd.copy_emit) begin
        copy_cnt <= copy_cnt - CW'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.cur_byte  = cur_byte;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.copy_last = copy_cnt == CW'(1);
  assign stat.fill_end  = sweep_addr == AW'(FILL_LAST);
  assign stat.ring_end  = sweep_addr == AW'(RING_SIZE - 1);

endmodule

`default_nettype wire

[design/lrd_ctrl.sv]
// controller: sequencing state machine and token state (flag bits, flags left, phase)
`default_nettype none

module lrd_ctrl
  import lrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      start_stream,
  input  wire lrd_stat_t stat,
  output logic           in_ready,
  output lrd_cmd_t       cmd
);

  ctrl_state_t  state, state_next;
  token_phase_t phase, phase_next;
  logic [7:0]   flag_bits, flag_bits_next;
  logic [3:0]   flags_left, flags_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      phase      <= PH_FLAG;
      flag_bits  <= '0;
      flags_left <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
    end
  end

  always_comb begin
    logic [3:0] left_dec;
    left_dec        = (flags_left != 4'd0) ? flags_left - 4'd1 : 4'd0;
    state_next      = state;
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (stat.ring_end) begin
          cmd.sweep_done = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (start_stream) begin
            cmd.stream_reset = 1'b1;
            phase_next       = PH_FLAG;
            flag_bits_next   = '0;
            flags_left_next  = '0;
            state_next       = ST_FILL;
          end else begin
            state_next = ST_DECODE;
          end
        end
      end
      ST_FILL: begin
        cmd.sweep_step = 1'b1;
        if (stat.fill_end) begin
          cmd.sweep_done = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (phase)
          PH_LIT: begin
            if (flag_bits[0]) begin
              if (stat.out_free) begin
                cmd.emit_lit    = 1'b1;
                flag_bits_next  = flag_bits >> 1;
                flags_left_next = left_dec;
                phase_next      = (left_dec == 4'd0) ? PH_FLAG : PH_LIT;
                state_next      = ST_IDLE;
              end
            end else begin
              cmd.save_pos = 1'b1;
              phase_next   = PH_POS;
              state_next   = ST_IDLE;
            end
          end
          PH_POS: begin
            cmd.copy_start = 1'b1;
            state_next     = ST_COPY;
          end
          default: begin
            flag_bits_next  = stat.cur_byte;
            flags_left_next = 4'd8;
            phase_next      = PH_LIT;
            state_next      = ST_IDLE;
          end
        endcase
      end
      ST_COPY: begin
        if (stat.out_free) begin
          cmd.copy_emit = 1'b1;
          if (stat.copy_last) begin
            flag_bits_next  = flag_bits >> 1;
            flags_left_next = left_dec;
            phase_next      = (left_dec == 4'd0) ? PH_FLAG : PH_LIT;
            state_next      = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/lzss_ring_decoder_top.sv]
// top level of the lzss ring decoder: apb register, controller and datapath
`default_nettype none

// Byte-serial LZSS decompressor built around a RING_SIZE-byte history ring
// held in a single-port-write, registered-read memory. One compressed byte
// is taken per input transfer; each decoded byte leaves as one output
// transfer carrying the byte, a kept flag against output_capacity, the
// running kept count and a run_last mark on the final byte of that input.
// Sequence: after reset the ring is cleared to zero by a pass over all
// RING_SIZE entries before the first transfer is taken. A flag byte, a
// literal and the first byte of a match are each accepted, then decoded.
// The second byte of a match is accepted, starts the ring read, then
// copies 3 to 18 bytes out, one ring read and one ring write per cycle
// while the output is free. An input with start_stream set first runs a
// fill pass that writes spaces into the first RING_SIZE - MAX_MATCH ring
// entries (1006 by default). Output stalls hold the copy in place. The
// next input transfer is taken while the last result still sits in the
// output register. output_capacity (byte address 0) may only be written
// while the decoder is idle.
module lzss_ring_decoder_top
  import lrd_pkg::*;
#(
  parameter int RING_SIZE        = 1024,
  parameter int MAX_MATCH        = 18,
  parameter int MIN_MATCH_OFFSET = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // compressed byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  input  wire logic        start_stream,
  // decoded byte output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       byte_value,
  output logic             kept,
  output logic             run_last,
  output logic [23:0]      kept_total
);

  // register 0 sits at byte address 0, word select is paddr[2]
  logic [23:0] output_capacity;
  logic        reg_sel;
  lrd_cmd_t    cmd;
  lrd_stat_t   stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= 24'hFFFFFF;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      output_capacity <= pwdata[23:0];
    end
  end

  // read back, low address bits ignored
  assign prdata = reg_sel ? {8'd0, output_capacity} : 32'd0;

  lrd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .start_stream (start_stream),
    .stat         (stat),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  lrd_datapath #(
    .RING_SIZE        (RING_SIZE),
    .MAX_MATCH        (MAX_MATCH),
    .MIN_MATCH_OFFSET (MIN_MATCH_OFFSET)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .capacity   (output_capacity),
    .byte_in    (byte_in),
    .out_ready  (out_ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .byte_value (byte_value),
    .kept       (kept),
    .run_last   (run_last),
    .kept_total (kept_total)
  );

endmodule

`default_nettype wire
